// ----- rtl/gpt_pkg.sv -----
// Shared types and constants for the game port axis timer.
package gpt_pkg;

   localparam int unsigned NumAxes   = 4;
   localparam int unsigned AxisW     = 12;
   localparam int unsigned TotalW    = 13;
   localparam int unsigned CompW     = 7;
   localparam int unsigned StepW     = 7;
   localparam int unsigned SampleW   = 8;
   localparam int unsigned BtnW      = 4;
   localparam int unsigned RspDataW  = 56;

   localparam logic [StepW-1:0]        BaseStep  = 7'd17;
   localparam logic signed [CompW-1:0] CompMin   = -7'sd12;
   localparam logic [AxisW-1:0]        FullScale = 12'd4095;

   // One input beat as held in the input register
   typedef struct packed {
      logic               start_req;
      logic [SampleW-1:0] port_sample;
   } item_type;

   // One result beat
   typedef struct packed {
      logic [BtnW-1:0]  buttons;
      logic [AxisW-1:0] stick_b_y;
      logic [AxisW-1:0] stick_b_x;
      logic [AxisW-1:0] stick_a_y;
      logic [AxisW-1:0] stick_a_x;
   } result_type;

endpackage

// ----- rtl/gpt_meas.sv -----
// Measurement state and per-beat update: tick total, axis counts, compensation.
module gpt_meas
   import gpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CompW-1:0] csr_wr_data,
   input  logic             item_fire,
   input  item_type         item,
   output logic             done,
   output result_type       result
);

   logic                    measuring_ff, measuring_in;
   logic [TotalW-1:0]       tick_total_ff, tick_total_in;
   logic [AxisW-1:0]        count_ff [NumAxes];
   logic [AxisW-1:0]        count_in [NumAxes];
   logic signed [CompW-1:0] comp_ff;

   logic signed [CompW-1:0] comp_clamped;
   logic [StepW-1:0]        step;
   logic [TotalW-1:0]       total_sum;
   logic                    axes_low;
   logic                    over_range;

   // Step per tick: 17 plus the compensation, clamped below at -12 (5..80)
   always_comb begin
      comp_clamped = (comp_ff < CompMin) ? CompMin : comp_ff;
      step         = BaseStep + StepW'(comp_clamped);
   end

   assign total_sum  = tick_total_ff + TotalW'(step);
   assign axes_low   = (item.port_sample[NumAxes-1:0] == '0);
   assign over_range = total_sum[TotalW-1];
   assign done       = !item.start_req && measuring_ff && (axes_low || over_range);

   // Result fields: full scale minus each count, buttons from this sample
   always_comb begin
      result.stick_a_x = FullScale - count_ff[0];
      result.stick_a_y = FullScale - count_ff[1];
      result.stick_b_x = FullScale - count_ff[2];
      result.stick_b_y = FullScale - count_ff[3];
      result.buttons   = item.port_sample[SampleW-1 -: BtnW];
   end

   // Next state
   always_comb begin
      measuring_in  = measuring_ff;
      tick_total_in = tick_total_ff;
      count_in      = count_ff;
      if (item.start_req) begin
         measuring_in  = 1'b1;
         tick_total_in = '0;
         for (int i = 0; i < NumAxes; i++) begin
            count_in[i] = '0;
         end
      end else if (measuring_ff) begin
         if (done) begin
            measuring_in = 1'b0;
         end else begin
            tick_total_in = total_sum;
            for (int i = 0; i < NumAxes; i++) begin
               if (item.port_sample[i]) begin
                  count_in[i] = total_sum[AxisW-1:0];
               end
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff  <= 1'b0;
         tick_total_ff <= '0;
         comp_ff       <= '0;
         for (int i = 0; i < NumAxes; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            comp_ff <= csr_wr_data;
         end
         if (item_fire) begin
            measuring_ff  <= measuring_in;
            tick_total_ff <= tick_total_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

// ----- rtl/gameport_axis_timer.sv -----
// Top level: game port RC timing reader with stream input and output.
//
//  channel | dir | handshake                  | payload
//  req     | in  | req_tvalid / req_tready    | tuser start_req, tdata port_sample
//  rsp     | out | rsp_tvalid / rsp_tready    | tdata four axes + buttons
//  csr     | in  | csr_wr_en                  | csr_wr_data speed_compensation
//
// One beat per cycle while a held rsp does not stall req: a beat is held in the
// input register, is applied to the measurement state and, if it ends a
// measurement, lands in the output register.
// Synchronous reset clears the control state, the counts and the compensation.
// A held rsp only stalls req when the beat in the input register ends a
// measurement; start and tick beats that give no result keep flowing.
module gameport_axis_timer
   import gpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // req
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SampleW-1:0]  req_tdata,   // [7:0] port_sample
   input  logic                req_tuser,   // [0] start_req
   // rsp
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [11:0] stick_a_x, [23:12] stick_a_y,
                                            // [35:24] stick_b_x, [47:36] stick_b_y,
                                            // [51:48] buttons, [55:52] zero
   // csr
   input  logic                csr_wr_en,
   input  logic [CompW-1:0]    csr_wr_data
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_data_ff;

   logic       done;
   result_type result;
   logic       advance;
   logic       out_free;

   // Measurement state and update
   gpt_meas u_meas (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_fire   (advance),
      .item        (in_item_ff),
      .done        (done),
      .result      (result)
   );

   // Flow control
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!done || out_free);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.start_req   <= req_tuser;
         in_item_ff.port_sample <= req_tdata;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && done;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && done) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RspDataW - $bits(result_type))'(0), out_data_ff};

endmodule

// ----- rtl/gpt_checker.sv -----
// Port-level checks for the game port axis timer, bound to the top level.
module gpt_checker
   import gpt_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   // A stalled result beat stays and holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   // Right after reset no result is pending and req is open
   a_reset_state: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

   // req only backs up behind a stalled result
   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without a stalled rsp beat");

   // Pad bits of the result beat are zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataW-1:$bits(result_type)] == '0)
      else $error("rsp pad bits not zero");

endmodule

bind gameport_axis_timer gpt_checker u_gpt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);

// ----- dv/gameport_axis_timer_chk.sv -----
// Checker for the game port axis timer: predicts readings from req beats and compares rsp beats.
module gameport_axis_timer_chk
   import gpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [SampleW-1:0]  req_tdata,   // [7:0] port_sample
   input  logic                req_tuser,   // [0] start_req
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,   // [11:0] a_x, [23:12] a_y, [35:24] b_x,
                                            // [47:36] b_y, [51:48] buttons
   input  logic                csr_wr_en,
   input  logic [CompW-1:0]    csr_wr_data,
   output int                  fail_count,
   output int                  pending_count
);

   localparam int ResW = $bits(result_type);

   // private copy of the block's state
   logic              meas_open;
   logic [TotalW-1:0] tick_sum;
   logic [AxisW-1:0]  axis_cnt [NumAxes];
   logic [CompW-1:0]  comp_reg;
   result_type        readings_q [$];
   int                errors;

   // ticks per sample: base step plus compensation, clamped at the low end
   function automatic logic [TotalW-1:0] tick_step(logic [CompW-1:0] comp);
      int sc;
      sc = int'($signed(comp));
      if (sc < int'(CompMin)) sc = int'(CompMin);
      return TotalW'(int'(BaseStep) + sc);
   endfunction

   // apply one accepted req beat, queue a reading if it closes the measurement
   task automatic measure_beat(input logic start, input logic [SampleW-1:0] smp);
      logic       done;
      result_type r;
      done = 1'b0;
      if (start) begin
         meas_open = 1'b1;
         tick_sum  = '0;
         for (int i = 0; i < NumAxes; i++) axis_cnt[i] = '0;
      end else if (meas_open) begin
         if (smp[NumAxes-1:0] == '0) begin
            done = 1'b1;
         end else begin
            tick_sum = tick_sum + tick_step(comp_reg);
            if (tick_sum > TotalW'(FullScale)) begin
               done = 1'b1;
            end else begin
               for (int i = 0; i < NumAxes; i++)
                  if (smp[i]) axis_cnt[i] = tick_sum[AxisW-1:0];
            end
         end
      end
      if (done) begin
         r.stick_a_x = FullScale - axis_cnt[0];
         r.stick_a_y = FullScale - axis_cnt[1];
         r.stick_b_x = FullScale - axis_cnt[2];
         r.stick_b_y = FullScale - axis_cnt[3];
         r.buttons   = smp[SampleW-1:NumAxes];
         meas_open   = 1'b0;
         readings_q.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         meas_open = 1'b0;
         tick_sum  = '0;
         for (int i = 0; i < NumAxes; i++) axis_cnt[i] = '0;
         comp_reg  = '0;
         readings_q.delete();
         errors    = 0;
      end else begin
         // compare a delivered reading with the oldest one predicted
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[ResW-1:0]);
            if (readings_q.size() == 0) begin
               $display("%0t: unexpected reading: expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = readings_q.pop_front();
               check_field("stick_a_x", int'(want.stick_a_x), int'(got.stick_a_x));
               check_field("stick_a_y", int'(want.stick_a_y), int'(got.stick_a_y));
               check_field("stick_b_x", int'(want.stick_b_x), int'(got.stick_b_x));
               check_field("stick_b_y", int'(want.stick_b_y), int'(got.stick_b_y));
               check_field("buttons", int'(want.buttons), int'(got.buttons));
               check_field("pad", 0, int'(rsp_tdata[RspDataW-1:ResW]));
            end
         end
         if (req_tvalid && req_tready) measure_beat(req_tuser, req_tdata);
         // register writes must come only while the block is idle; the block does not enforce it
         if (csr_wr_en) comp_reg = csr_wr_data;
      end
      fail_count    <= errors;
      pending_count <= readings_q.size();
   end

endmodule

// ----- dv/gameport_axis_timer_tb.sv -----
// Testbench top for the game port axis timer: clock, reset, stimulus and verdict.
module gameport_axis_timer_tb
   import gpt_pkg::*;
();

   localparam int Items      = 800;
   localparam int CycleLimit = 200000;
   localparam int NumSegs    = 6;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [SampleW-1:0]  req_tdata;   // [7:0] port_sample
   logic                req_tuser;   // [0] start_req
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // [11:0] a_x, [23:12] a_y, [35:24] b_x,
                                     // [47:36] b_y, [51:48] buttons
   logic                csr_wr_en;
   logic [CompW-1:0]    csr_wr_data;

   int fail_count;
   int pending_count;
   int cycles;
   int beats_sent;
   int send_idle_pct;
   int rsp_idle_pct;

   gameport_axis_timer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   gameport_axis_timer_chk u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // one req beat, with random gaps ahead of it; returns once accepted
   task automatic send_beat(input logic start, input logic [SampleW-1:0] smp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // drain everything in flight, then write the compensation register
   task automatic write_comp(input logic [CompW-1:0] value);
      req_tvalid <= 1'b0;
      // let the prediction of the last accepted beat settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // one measurement: start, ticks with axes decaying at random, closing tick
   task automatic run_measurement();
      int         dur [NumAxes];
      int         n_ticks;
      int         restart_at;
      bit         long_run;
      bit         noisy;
      logic [3:0] axes;
      n_ticks  = 0;
      long_run = ($urandom_range(0, 11) == 0);
      noisy    = ($urandom_range(0, 6) == 0);
      // stray ticks while idle
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) send_beat(1'b0, SampleW'($urandom));
      for (int i = 0; i < NumAxes; i++) begin
         dur[i] = long_run ? $urandom_range(0, 300) : $urandom_range(0, 25);
         if (dur[i] > n_ticks) n_ticks = dur[i];
      end
      restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_ticks) : -1;
      send_beat(1'b1, SampleW'($urandom));
      for (int t = 0; t < n_ticks; t++) begin
         if (t == restart_at) send_beat(1'b1, SampleW'($urandom));
         for (int i = 0; i < NumAxes; i++) axes[i] = (dur[i] > t);
         if (noisy) axes = 4'($urandom);
         send_beat(1'b0, {4'($urandom), axes});
      end
      send_beat(1'b0, {4'($urandom), 4'h0});
   endtask

   initial begin
      logic [CompW-1:0] seg_comp [NumSegs];
      logic [CompW-1:0] value;
      seg_comp = '{7'h40, 7'h3F, 7'h73, 7'h74, 7'h00, 7'h00};
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      beats_sent     = 0;
      send_idle_pct  = 30;
      rsp_idle_pct   = 68;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_comp(7'h00);

      // directed: idle ticks, immediate end, button extremes, restart
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, 8'h00);
      send_beat(1'b1, 8'hFF);
      send_beat(1'b0, 8'h00);
      send_beat(1'b1, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, 8'h5A);
      send_beat(1'b0, 8'hA5);
      send_beat(1'b0, 8'hF0);
      send_beat(1'b1, 8'h00);
      send_beat(1'b0, 8'h0F);
      send_beat(1'b0, 8'h0F);
      send_beat(1'b1, 8'hAA);
      send_beat(1'b0, 8'h31);
      send_beat(1'b0, 8'hC0);
      send_beat(1'b1, 8'h55);
      send_beat(1'b0, 8'h01);
      send_beat(1'b0, 8'h02);
      send_beat(1'b0, 8'h04);
      send_beat(1'b0, 8'h08);
      send_beat(1'b0, 8'h90);

      // random segments: idle pattern changes every two, compensation every one
      for (int s = 0; s < NumSegs; s++) begin
         case (s / 2)
            0: begin
               send_idle_pct = 30;
               rsp_idle_pct  = 68;
            end
            1: begin
               send_idle_pct = 68;
               rsp_idle_pct  = 30;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         value = (s == NumSegs - 1) ? CompW'($urandom_range(0, 127)) : seg_comp[s];
         write_comp(value);
         while (beats_sent < Items * (s + 1) / NumSegs) run_measurement();
      end

      // drain and give the verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/gpt_pkg.sv
rtl/gpt_meas.sv
rtl/gameport_axis_timer.sv
rtl/gpt_checker.sv
dv/gameport_axis_timer_chk.sv
dv/gameport_axis_timer_tb.sv
